// ===== hw/rtl/pfrq_pkg.sv =====
// pfrq_pkg: field widths, op codes, register map and the command and status
// structs shared by the paced frame release queue modules.
// Depends on nothing.
`timescale 1ns / 1ps

package pfrq_pkg;

  // payload field widths
  localparam int OP_W        = 2;
  localparam int STAMP_W     = 64;
  localparam int DUE_W       = 63;
  localparam int SIZE_W      = 31;
  localparam int OCC_REP_W   = 5;
  localparam int BYTES_REP_W = 35;
  localparam int OVF_W       = 32;

  // configuration register widths and reset values
  localparam int CEIL_W  = 36;
  localparam int SLACK_W = 30;
  localparam logic [CEIL_W-1:0]  CEIL_RESET  = 36'd134217728;
  localparam logic [SLACK_W-1:0] SLACK_RESET = 30'd2000000;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;
  localparam logic [ADDR_W-1:0] ADDR_CEIL  = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_SLACK = 4'h8;

  // op codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // result kinds
  localparam logic KIND_PUSH    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // latch the input request
    logic clear;     // empty the queue
    logic push;      // store a frame if there is room and emit push status
    logic rs_read;   // read stamp of the entry being rescheduled
    logic rs_write;  // write the new due time and step to the next entry
    logic hd_read;   // read the head entry
    logic rel;       // release the head entry
    logic flush;     // emit the held release as the final result
  } pfrq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic rs_last;
    logic due_release;
    logic pend_valid;
    logic out_free;
  } pfrq_stat_t;

endpackage

// ===== hw/rtl/paced_frame_release_queue.sv =====
// paced_frame_release_queue: top level with the configuration registers,
// controller and datapath. Depends on pfrq_pkg, pfrq_ctrl and pfrq_dp.
//
// Usage: requests enter on in_valid/in_ready with op push, tick or clear.
// A push gives one status result; a tick gives one result per released
// frame, the final one marked by last; clear and unknown ops give none.
// Results leave on out_valid/out_ready from an output register.
// One request at a time. On a tick with a valid playout offset the due
// time of every queued entry is rewritten first; then the head entries
// are checked in turn and released. Every reschedule is a read and a
// write, and every head check a read and a compare, on the single-port
// descriptor memories. Clear acts as the request is accepted.
// A stalled receiver holds the sequencer at the next result until the
// output register drains; one release is held internally until the next
// head decision shows whether it is the last.
// Reset empties the queue, zeroes the peak and overflow counters and
// restores the register defaults; descriptor memories are not cleared.
// Registers: byte_ceiling at 0x0, slack_time at 0x8, 64-bit data.
`timescale 1ns / 1ps

module paced_frame_release_queue
  import pfrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           op,
  input  logic signed [STAMP_W-1:0] frame_stamp,
  input  logic [DUE_W-1:0]          frame_due,
  input  logic [SIZE_W-1:0]         frame_size,
  input  logic [DUE_W-1:0]          now_time,
  input  logic                      offset_valid,
  input  logic signed [STAMP_W-1:0] playout_offset,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      kind,
  output logic                      accepted,
  output logic signed [STAMP_W-1:0] out_stamp,
  output logic [DUE_W-1:0]          out_time,
  output logic                      early,
  output logic                      last,
  output logic [OCC_REP_W-1:0]      occupancy,
  output logic [BYTES_REP_W-1:0]    queued_bytes,
  output logic [OCC_REP_W-1:0]      peak_occupancy,
  output logic [OVF_W-1:0]          overflow_total
);

  logic [CEIL_W-1:0]  byte_ceiling;
  logic [SLACK_W-1:0] slack_time;
  logic               cfg_wr;
  pfrq_cmd_t          cmd;
  pfrq_stat_t         stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register writes select the word by paddr[3]
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_ceiling <= CEIL_RESET;
      slack_time   <= SLACK_RESET;
    end else if (cfg_wr) begin
      if (paddr[3] == ADDR_SLACK[3]) begin
        slack_time <= pwdata[SLACK_W-1:0];
      end else begin
        byte_ceiling <= pwdata[CEIL_W-1:0];
      end
    end
  end

  // register read back
  always_comb begin
    priority if (paddr == ADDR_CEIL) begin
      prdata = DATA_W'(byte_ceiling);
    end else if (paddr == ADDR_SLACK) begin
      prdata = DATA_W'(slack_time);
    end else begin
      prdata = '0;
    end
  end

  pfrq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .offset_valid (offset_valid),
    .stat         (stat),
    .cmd          (cmd)
  );

  pfrq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .byte_ceiling   (byte_ceiling),
    .slack_time     (slack_time),
    .frame_stamp    (frame_stamp),
    .frame_due      (frame_due),
    .frame_size     (frame_size),
    .now_time       (now_time),
    .playout_offset (playout_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .accepted       (accepted),
    .out_stamp      (out_stamp),
    .out_time       (out_time),
    .early          (early),
    .last           (last),
    .occupancy      (occupancy),
    .queued_bytes   (queued_bytes),
    .peak_occupancy (peak_occupancy),
    .overflow_total (overflow_total)
  );

endmodule

// ===== hw/rtl/pfrq_ram.sv =====
// pfrq_ram: generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pfrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data holds while idle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hw/rtl/pfrq_ctrl.sv =====
// pfrq_ctrl: sequencer for push, clear, reschedule, head release and result flush.
// Depends on pfrq_pkg for op codes and the command and status structs.
`timescale 1ns / 1ps

module pfrq_ctrl
  import pfrq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] op,
  input  logic            offset_valid,
  input  pfrq_stat_t      stat,
  output pfrq_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUSH   = 3'd1;
  localparam logic [2:0] S_RS_RD  = 3'd2;
  localparam logic [2:0] S_RS_WR  = 3'd3;
  localparam logic [2:0] S_HD_RD  = 3'd4;
  localparam logic [2:0] S_HD_CHK = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (op)
            OP_PUSH: state_next = S_PUSH;
            OP_TICK: begin
              if (offset_valid && !stat.count_zero) state_next = S_RS_RD;
              else state_next = S_HD_RD;
            end
            OP_CLEAR: cmd.clear = 1'b1;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RS_RD: begin
        cmd.rs_read = 1'b1;
        state_next  = S_RS_WR;
      end
      S_RS_WR: begin
        cmd.rs_write = 1'b1;
        state_next   = stat.rs_last ? S_HD_RD : S_RS_RD;
      end
      S_HD_RD: begin
        if (stat.count_zero) begin
          state_next = S_FLUSH;
        end else begin
          cmd.hd_read = 1'b1;
          state_next  = S_HD_CHK;
        end
      end
      S_HD_CHK: begin
        if (!stat.due_release) begin
          state_next = S_FLUSH;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.rel    = 1'b1;
          state_next = S_HD_RD;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/pfrq_dp.sv =====
// pfrq_dp: descriptor memories, queue counters, due test, held release and
// output register. Depends on pfrq_pkg and pfrq_ram.
`timescale 1ns / 1ps

module pfrq_dp
  import pfrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pfrq_cmd_t                 cmd,
  output pfrq_stat_t                stat,
  input  logic [CEIL_W-1:0]         byte_ceiling,
  input  logic [SLACK_W-1:0]        slack_time,
  input  logic signed [STAMP_W-1:0] frame_stamp,
  input  logic [DUE_W-1:0]          frame_due,
  input  logic [SIZE_W-1:0]         frame_size,
  input  logic [DUE_W-1:0]          now_time,
  input  logic signed [STAMP_W-1:0] playout_offset,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      kind,
  output logic                      accepted,
  output logic signed [STAMP_W-1:0] out_stamp,
  output logic [DUE_W-1:0]          out_time,
  output logic                      early,
  output logic                      last,
  output logic [OCC_REP_W-1:0]      occupancy,
  output logic [BYTES_REP_W-1:0]    queued_bytes,
  output logic [OCC_REP_W-1:0]      peak_occupancy,
  output logic [OVF_W-1:0]          overflow_total
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int BYTES_W = SIZE_W + CNT_W;
  localparam int CMP_W   = (BYTES_W > CEIL_W) ? BYTES_W : CEIL_W;
  localparam int SS_W    = STAMP_W + SIZE_W;

  // queue state
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   head_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [BYTES_W-1:0] bytes;
  logic [BYTES_W-1:0] bytes_next;
  logic [CNT_W-1:0]   peak;
  logic [CNT_W-1:0]   peak_next;
  logic [OVF_W-1:0]   ovf;
  logic [OVF_W-1:0]   ovf_next;
  logic [IDX_W-1:0]   rs_idx;

  // latched request
  logic signed [STAMP_W-1:0] req_stamp;
  logic [DUE_W-1:0]          req_due;
  logic [SIZE_W-1:0]         req_size;
  logic signed [STAMP_W-1:0] req_offset;
  logic [DUE_W:0]            now_slack;

  // held release
  logic                      pend_valid;
  logic signed [STAMP_W-1:0] pend_stamp;
  logic [DUE_W-1:0]          pend_due;
  logic                      pend_early;
  logic [OCC_REP_W-1:0]      pend_occ;
  logic [BYTES_REP_W-1:0]    pend_bytes;
  logic [OCC_REP_W-1:0]      pend_peak;
  logic [OVF_W-1:0]          pend_ovf;

  // memory ports
  logic              ss_en, ss_we, due_en, due_we;
  logic [IDX_W-1:0]  ss_addr, due_addr;
  logic [SS_W-1:0]   ss_rd;
  logic [DUE_W-1:0]  due_rd, due_wd;
  logic signed [STAMP_W-1:0] stamp_rd;
  logic [SIZE_W-1:0] size_rd;

  // derived values
  logic              room;
  logic              push_ok;
  logic              out_free;
  logic              out_load;
  logic [CNT_W:0]    push_sum;
  logic [IDX_W-1:0]  slot_push;
  logic [IDX_W:0]    rs_sum;
  logic [IDX_W-1:0]  slot_rs;
  logic [STAMP_W:0]  resched_sum;
  logic [CNT_W+4:0]  occ_ext, peak_ext;
  logic [BYTES_W+BYTES_REP_W-1:0] bytes_ext;
  logic [OCC_REP_W-1:0]   occ_rep, peak_rep;
  logic [BYTES_REP_W-1:0] bytes_rep;

  assign stamp_rd = ss_rd[SS_W-1:SIZE_W];
  assign size_rd  = ss_rd[SIZE_W-1:0];

  // room check against both ceilings
  assign room    = (count < CNT_W'(QUEUE_DEPTH)) &&
                   (CMP_W'(bytes) < CMP_W'(byte_ceiling));
  assign push_ok = cmd.push && room;

  // ring slots for the tail and for the entry being rescheduled
  assign push_sum  = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign slot_push = (push_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                     IDX_W'(push_sum - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(push_sum);
  assign rs_sum    = (IDX_W+1)'(head) + (IDX_W+1)'(rs_idx);
  assign slot_rs   = (rs_sum >= (IDX_W+1)'(QUEUE_DEPTH)) ?
                     IDX_W'(rs_sum - (IDX_W+1)'(QUEUE_DEPTH)) : IDX_W'(rs_sum);

  // new due time: stamp plus offset, clamped to the unsigned range
  assign resched_sum = {stamp_rd[STAMP_W-1], stamp_rd} +
                       {req_offset[STAMP_W-1], req_offset};
  always_comb begin
    if (resched_sum[STAMP_W]) begin
      due_wd = '0;
    end else if (resched_sum[STAMP_W-1]) begin
      due_wd = '1;
    end else begin
      due_wd = resched_sum[DUE_W-1:0];
    end
    if (push_ok) due_wd = req_due;
  end

  // memory access selection
  assign ss_en    = push_ok || cmd.rs_read || cmd.hd_read;
  assign ss_we    = push_ok;
  assign ss_addr  = push_ok ? slot_push : (cmd.rs_read ? slot_rs : head);
  assign due_en   = push_ok || cmd.rs_write || cmd.hd_read;
  assign due_we   = push_ok || cmd.rs_write;
  assign due_addr = push_ok ? slot_push : (cmd.rs_write ? slot_rs : head);

  pfrq_ram #(.WIDTH(SS_W), .DEPTH(QUEUE_DEPTH)) u_ram_ss (
    .clk   (clk),
    .en    (ss_en),
    .we    (ss_we),
    .addr  (ss_addr),
    .wdata ({req_stamp, req_size}),
    .rdata (ss_rd)
  );

  pfrq_ram #(.WIDTH(DUE_W), .DEPTH(QUEUE_DEPTH)) u_ram_due (
    .clk   (clk),
    .en    (due_en),
    .we    (due_we),
    .addr  (due_addr),
    .wdata (due_wd),
    .rdata (due_rd)
  );

  // counter updates
  always_comb begin
    head_next  = head;
    count_next = count;
    bytes_next = bytes;
    peak_next  = peak;
    ovf_next   = ovf;
    if (cmd.clear) begin
      head_next  = '0;
      count_next = '0;
      bytes_next = '0;
    end else if (push_ok) begin
      count_next = count + CNT_W'(1);
      bytes_next = bytes + BYTES_W'(req_size);
      if (count_next > peak) peak_next = count_next;
    end else if (cmd.rel) begin
      head_next  = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
      count_next = count - CNT_W'(1);
      bytes_next = bytes - BYTES_W'(size_rd);
      if (!room && (ovf != '1)) ovf_next = ovf + OVF_W'(1);
    end
  end

  // reported values saturate at the result field widths
  assign occ_ext   = (CNT_W+5)'(count_next);
  assign peak_ext  = (CNT_W+5)'(peak_next);
  assign bytes_ext = (BYTES_W+BYTES_REP_W)'(bytes_next);
  assign occ_rep   = (occ_ext > (CNT_W+5)'(31)) ? '1 : occ_ext[OCC_REP_W-1:0];
  assign peak_rep  = (peak_ext > (CNT_W+5)'(31)) ? '1 : peak_ext[OCC_REP_W-1:0];
  assign bytes_rep = (bytes_ext > (BYTES_W+BYTES_REP_W)'({BYTES_REP_W{1'b1}})) ?
                     '1 : bytes_ext[BYTES_REP_W-1:0];

  // status to the controller
  assign out_free         = !out_valid || out_ready;
  assign stat.count_zero  = (count == '0);
  assign stat.rs_last     = ((CNT_W'(rs_idx) + CNT_W'(1)) == count);
  assign stat.due_release = !room || !({1'b0, due_rd} > now_slack);
  assign stat.pend_valid  = pend_valid;
  assign stat.out_free    = out_free;

  assign out_load = cmd.push || (cmd.rel && pend_valid) || cmd.flush;

  // queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      bytes  <= '0;
      peak   <= '0;
      ovf    <= '0;
      rs_idx <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      bytes <= bytes_next;
      peak  <= peak_next;
      ovf   <= ovf_next;
      if (cmd.accept) begin
        rs_idx <= '0;
      end else if (cmd.rs_write) begin
        rs_idx <= rs_idx + IDX_W'(1);
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_stamp  <= frame_stamp;
      req_due    <= frame_due;
      req_size   <= frame_size;
      req_offset <= playout_offset;
      now_slack  <= {1'b0, now_time} + (DUE_W+1)'(slack_time);
    end
  end

  // held release: emitted once the next head decision is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.rel) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rel) begin
      pend_stamp <= stamp_rd;
      pend_due   <= due_rd;
      pend_early <= !room;
      pend_occ   <= occ_rep;
      pend_bytes <= bytes_rep;
      pend_peak  <= peak_rep;
      pend_ovf   <= ovf_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      kind           <= KIND_PUSH;
      accepted       <= room;
      out_stamp      <= '0;
      out_time       <= '0;
      early          <= 1'b0;
      last           <= 1'b1;
      occupancy      <= occ_rep;
      queued_bytes   <= bytes_rep;
      peak_occupancy <= peak_rep;
      overflow_total <= ovf_next;
    end else if (out_load) begin
      kind           <= KIND_RELEASE;
      accepted       <= 1'b0;
      out_stamp      <= pend_stamp;
      out_time       <= pend_due;
      early          <= pend_early;
      last           <= cmd.flush;
      occupancy      <= pend_occ;
      queued_bytes   <= pend_bytes;
      peak_occupancy <= pend_peak;
      overflow_total <= pend_ovf;
    end
  end

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_load && out_valid) |-> out_ready)
    else $error("output register overwritten while stalled");

  // an empty queue holds no bytes
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (bytes == '0))
    else $error("byte total nonzero with empty queue");

  // the peak never falls below the current occupancy
  assert property (@(posedge clk) disable iff (rst)
    peak >= count)
    else $error("peak below occupancy");

  // a release never happens on an empty queue
  assert property (@(posedge clk) disable iff (rst)
    cmd.rel |-> (count != '0))
    else $error("release from empty queue");

endmodule
